FILE: src/psa_pkg.sv
package psa_pkg;

  // operand and packing widths
  localparam int unsigned HalfW   = 64;
  localparam int unsigned VecW    = 2 * HalfW;
  localparam int unsigned OpW     = 4;
  localparam int unsigned OrderW  = 8;
  localparam int unsigned ScalarW = 32;
  localparam int unsigned InDataW = 4 * HalfW + OrderW + ScalarW;
  localparam int unsigned InUserW = OpW + 1;
  localparam int unsigned ShiftW  = 5;

  // opcodes
  typedef enum logic [OpW-1:0] {
    OP_XOR    = 4'd0,
    OP_AND    = 4'd1,
    OP_ADDB   = 4'd2,
    OP_CMPGTB = 4'd3,
    OP_SHUFW  = 4'd4,
    OP_MOVD   = 4'd5,
    OP_UNPB   = 4'd6,
    OP_UNPW   = 4'd7,
    OP_UNPD   = 4'd8,
    OP_UNPQ   = 4'd9,
    OP_SRLD   = 4'd10,
    OP_SLLD   = 4'd11
  } op_e;

  // which result group the last stage picks
  typedef enum logic [1:0] {
    SEL_LOGIC,
    SEL_PERM,
    SEL_SHIFT,
    SEL_DEST
  } res_sel_e;

  // decode stage contents
  typedef struct packed {
    op_e                op;
    res_sel_e           sel;
    logic               wide;
    logic               ill;
    logic               shift_big;
    logic [VecW-1:0]    dest;
    logic [VecW-1:0]    src;
    logic [OrderW-1:0]  order;
    logic [ScalarW-1:0] scalar;
  } s1_t;

  // compute stage contents
  typedef struct packed {
    res_sel_e        sel;
    logic            wide;
    logic            ill;
    logic [VecW-1:0] dest;
    logic [VecW-1:0] logic_res;
    logic [VecW-1:0] perm_res;
    logic [VecW-1:0] shift_res;
  } s2_t;

endpackage

FILE: src/packed_simd_alu_subset.sv
// channel   dir  tdata (lsb first)                                  tuser
// s_axis    in   dest_lo, dest_hi, src_lo, src_hi, shuffle_order,   req_type, wide_mode
//                scalar_value (296 bits)
// m_axis    out  result_lo, result_hi (128 bits)                    illegal_op
//
// one transfer per cycle in and out while m_axis is not stalled; three register
// stages (decode, compute, select), and a result passes through all three
// registers in that order before it is valid on m_axis
// rst_ni clears the stage valid bits only; payload registers are not reset
// a stall on m_axis backs up stage by stage; a stage takes new data whenever
// it is empty or its contents move on, so bubbles are squeezed out
module packed_simd_alu_subset
  import psa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // dest_lo, dest_hi, src_lo, src_hi, shuffle_order, scalar_value
  input  logic [InDataW-1:0] s_axis_tdata,
  // req_type, wide_mode
  input  logic [InUserW-1:0] s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // result_lo, result_hi
  output logic [VecW-1:0]    m_axis_tdata,
  // illegal_op
  output logic [0:0]         m_axis_tuser
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  logic [VecW-1:0] res_d, res_q;
  logic ill_d, ill_q;

  // stage advance conditions
  assign rdy3 = !v3_q || m_axis_tready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // decode: unpack fields, drop high halves in mmx mode, classify opcode
  always_comb begin
    logic wide;
    wide           = s_axis_tuser[OpW];
    s1_d.op        = op_e'(s_axis_tuser[OpW-1:0]);
    s1_d.wide      = wide;
    s1_d.dest      = {wide ? s_axis_tdata[2*HalfW-1:HalfW] : '0,
                      s_axis_tdata[HalfW-1:0]};
    s1_d.src       = {wide ? s_axis_tdata[4*HalfW-1:3*HalfW] : '0,
                      s_axis_tdata[3*HalfW-1:2*HalfW]};
    s1_d.order     = s_axis_tdata[4*HalfW +: OrderW];
    s1_d.scalar    = s_axis_tdata[4*HalfW+OrderW +: ScalarW];
    s1_d.shift_big = |s_axis_tdata[3*HalfW-1:2*HalfW+ShiftW];
    s1_d.ill       = 1'b0;
    s1_d.sel       = SEL_DEST;
    unique case (s1_d.op) inside
      OP_XOR, OP_AND, OP_ADDB, OP_CMPGTB: s1_d.sel = SEL_LOGIC;
      OP_MOVD, OP_UNPB, OP_UNPW, OP_UNPD: s1_d.sel = SEL_PERM;
      OP_SRLD, OP_SLLD:                   s1_d.sel = SEL_SHIFT;
      OP_SHUFW: begin
        s1_d.ill = wide;
        s1_d.sel = wide ? SEL_DEST : SEL_PERM;
      end
      OP_UNPQ: begin
        s1_d.ill = !wide;
        s1_d.sel = wide ? SEL_PERM : SEL_DEST;
      end
      default: begin
        s1_d.ill = 1'b1;
        s1_d.sel = SEL_DEST;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) s1_q <= s1_d;
  end

  // compute: logic/byte group, permute group and shift group in parallel
  always_comb begin
    logic [VecW-1:0]    add_b, cmp_b, unp_b, unp_w, unp_d, unp_q;
    logic [HalfW-1:0]   shuf;
    logic [ShiftW-1:0]  sh;
    logic [1:0]         wsel;
    add_b = '0;
    cmp_b = '0;
    unp_b = '0;
    unp_w = '0;
    unp_d = '0;
    shuf  = '0;
    sh    = s1_q.src[ShiftW-1:0];
    wsel  = '0;

    // byte lanes
    for (int i = 0; i < VecW / 8; i++) begin
      add_b[8*i +: 8] = s1_q.dest[8*i +: 8] + s1_q.src[8*i +: 8];
      cmp_b[8*i +: 8] = ($signed(s1_q.dest[8*i +: 8]) > $signed(s1_q.src[8*i +: 8]))
                        ? 8'hFF : 8'h00;
    end

    // interleave low elements
    for (int i = 0; i < 8; i++) begin
      unp_b[16*i +: 16] = {s1_q.src[8*i +: 8], s1_q.dest[8*i +: 8]};
    end
    for (int i = 0; i < 4; i++) begin
      unp_w[32*i +: 32] = {s1_q.src[16*i +: 16], s1_q.dest[16*i +: 16]};
    end
    for (int i = 0; i < 2; i++) begin
      unp_d[64*i +: 64] = {s1_q.src[32*i +: 32], s1_q.dest[32*i +: 32]};
    end
    unp_q = {s1_q.src[HalfW-1:0], s1_q.dest[HalfW-1:0]};

    // word shuffle of the low source half
    for (int k = 0; k < 4; k++) begin
      wsel = s1_q.order[2*k +: 2];
      shuf[16*k +: 16] = s1_q.src[16*wsel +: 16];
    end

    // logic and byte group
    case (s1_q.op)
      OP_XOR:  s2_d.logic_res = s1_q.dest ^ s1_q.src;
      OP_AND:  s2_d.logic_res = s1_q.dest & s1_q.src;
      OP_ADDB: s2_d.logic_res = add_b;
      default: s2_d.logic_res = cmp_b;
    endcase

    // permute group
    case (s1_q.op)
      OP_SHUFW: s2_d.perm_res = {{HalfW{1'b0}}, shuf};
      OP_MOVD:  s2_d.perm_res = {{(VecW-ScalarW){1'b0}}, s1_q.scalar};
      OP_UNPB:  s2_d.perm_res = unp_b;
      OP_UNPW:  s2_d.perm_res = unp_w;
      OP_UNPD:  s2_d.perm_res = unp_d;
      default:  s2_d.perm_res = unp_q;
    endcase

    // dword shifts, cleared when the count is above 31
    for (int k = 0; k < VecW / 32; k++) begin
      if (s1_q.shift_big) begin
        s2_d.shift_res[32*k +: 32] = '0;
      end else if (s1_q.op == OP_SLLD) begin
        s2_d.shift_res[32*k +: 32] = s1_q.dest[32*k +: 32] << sh;
      end else begin
        s2_d.shift_res[32*k +: 32] = s1_q.dest[32*k +: 32] >> sh;
      end
    end

    s2_d.sel  = s1_q.sel;
    s2_d.wide = s1_q.wide;
    s2_d.ill  = s1_q.ill;
    s2_d.dest = s1_q.dest;
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) s2_q <= s2_d;
  end

  // select: pick the group, clear the high half in mmx mode
  always_comb begin
    logic [VecW-1:0] pick;
    case (s2_q.sel)
      SEL_LOGIC: pick = s2_q.logic_res;
      SEL_PERM:  pick = s2_q.perm_res;
      SEL_SHIFT: pick = s2_q.shift_res;
      default:   pick = s2_q.dest;
    endcase
    res_d = {s2_q.wide ? pick[VecW-1:HalfW] : '0, pick[HalfW-1:0]};
    ill_d = s2_q.ill;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_q <= res_d;
      ill_q <= ill_d;
    end
  end

  // output channel
  assign m_axis_tvalid   = v3_q;
  assign m_axis_tdata    = res_q;
  assign m_axis_tuser[0] = ill_q;

`ifndef SYNTHESIS
  // mmx results carry a zero high half
  a_mmx_hi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !s2_q.wide |-> res_d[VecW-1:HalfW] == '0)
    else $error("mmx result with nonzero high half");

  // an illegal item always returns the destination
  a_ill_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && s2_q.ill |-> s2_q.sel == SEL_DEST)
    else $error("illegal item not routed to destination");

  // a blocked decode stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q && $stable(s1_q))
    else $error("decode stage lost or changed a stalled item");

  // a blocked compute stage keeps its item
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && $stable(s2_q))
    else $error("compute stage lost or changed a stalled item");
`endif

endmodule
